// ===== rtl/core/percent_escape_decoder_macros.svh =====
// Assertion macros shared by the percent escape decoder modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PERCENT_ESCAPE_DECODER_MACROS_SVH
`define PERCENT_ESCAPE_DECODER_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define PED_ASSERT_IMP(lbl, ck, rn, pre, post, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside of reset.
`define PED_ASSERT_NXT(lbl, ck, rn, pre, post, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/ped_pkg.sv =====
// Shared types, constants and helper functions for the percent escape decoder.
// Depends on nothing; used by every module of the block.
package ped_pkg;

    // Width of the per-string byte counter.
    localparam int COUNT_BITS = 16;
    localparam int TOTAL_W    = 16;
    localparam int LIMIT_W    = 16;
    localparam int CMP_W      = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Character constants.
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_DIGIT0  = 8'h30;
    localparam logic [7:0] CHAR_DIGIT9  = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] HEX_TEN      = 8'h0a;

    // Reset value of the output limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hffff;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } ped_in_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               run_last;
        logic               string_done;
        logic [TOTAL_W-1:0] out_total;
    } ped_out_t;

    // Escape tracking state.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_HEX  = 3'b100
    } ped_phase_t;

    // One queued work item: up to three bytes to deliver for one input.
    typedef struct packed {
        logic [2:0][7:0]       bytes;
        logic [1:0]            num;       // results to deliver, 1 to 3
        logic                  has_byte;  // 0 for an empty end marker
        logic                  str_end;
        logic [COUNT_BITS-1:0] base;      // byte count before this item
    } ped_op_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } ped_qstat_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } ped_hex_t;

    // Decode one hex digit of either case.
    function automatic ped_hex_t hex_decode(input logic [7:0] c);
        ped_hex_t h;
        h.ok  = 1'b0;
        h.val = 4'h0;
        if (c >= CHAR_DIGIT0 && c <= CHAR_DIGIT9) begin
            h.ok  = 1'b1;
            h.val = 4'(c - CHAR_DIGIT0);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            h.ok  = 1'b1;
            h.val = 4'(HEX_TEN + c - CHAR_LOWER_A);
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            h.ok  = 1'b1;
            h.val = 4'(HEX_TEN + c - CHAR_UPPER_A);
        end
        return h;
    endfunction

    // Effective cap: the smaller of the limit and the counter's maximum.
    function automatic logic [COUNT_BITS-1:0] cap_of(input logic [LIMIT_W-1:0] lim);
        logic [CMP_W-1:0] lw;
        logic [CMP_W-1:0] mw;
        lw = CMP_W'(lim);
        mw = CMP_W'({COUNT_BITS{1'b1}});
        return COUNT_BITS'((lw < mw) ? lw : mw);
    endfunction

    // Count to output total field.
    function automatic logic [TOTAL_W-1:0] to_total(input logic [COUNT_BITS-1:0] v);
        return TOTAL_W'(v);
    endfunction

endpackage

// ===== rtl/core/ped_front.sv =====
// Front end: accepts input bytes, tracks escapes, applies the length cap
// and builds queue items. Depends on ped_pkg and the assertion macros.
`include "percent_escape_decoder_macros.svh"

module ped_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  ped_pkg::ped_in_t              src_item,
    input  logic                          limit_wr_en,
    input  logic [ped_pkg::LIMIT_W-1:0]   limit_wr_data,
    input  ped_pkg::ped_qstat_t           qstat,
    output logic                          push,
    output ped_pkg::ped_op_t              push_op
);

    ped_pkg::ped_phase_t                 phase_reg, phase_next;
    logic [7:0]                          held_reg, held_next;
    logic [ped_pkg::COUNT_BITS-1:0]      count_reg, count_next;
    logic [ped_pkg::COUNT_BITS-1:0]      cap_reg;

    logic                                accept;
    logic                                str_end;
    ped_pkg::ped_hex_t                   cur_hex;
    ped_pkg::ped_hex_t                   held_hex;
    logic [7:0]                          cand [3];
    logic [1:0]                          cand_n;
    logic [ped_pkg::COUNT_BITS-1:0]      room;
    logic [1:0]                          room_sat;
    logic [1:0]                          emit_n;

    // The front stalls only when the queue has no free entry.
    assign src_stall = qstat.full;
    assign accept    = src_valid && !qstat.full;
    assign str_end   = src_item.in_last || (src_item.in_byte == ped_pkg::CHAR_NUL);
    assign cur_hex   = ped_pkg::hex_decode(src_item.in_byte);
    assign held_hex  = ped_pkg::hex_decode(held_reg);

    // Classify the byte: list of candidate output bytes and next escape state.
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        cand[0]    = ped_pkg::CHAR_NUL;
        cand[1]    = ped_pkg::CHAR_NUL;
        cand[2]    = ped_pkg::CHAR_NUL;
        cand_n     = 2'd0;

        if (src_item.in_byte != ped_pkg::CHAR_NUL)
        begin
            unique case (phase_reg)
                ped_pkg::PH_PCT:
                begin
                    if (cur_hex.ok)
                    begin
                        held_next  = src_item.in_byte;
                        phase_next = ped_pkg::PH_HEX;
                    end
                    else
                    begin
                        cand[cand_n] = ped_pkg::CHAR_PERCENT;
                        cand_n       = cand_n + 2'd1;
                        // The breaking byte starts afresh.
                        if (src_item.in_byte == ped_pkg::CHAR_PERCENT)
                        begin
                            phase_next = ped_pkg::PH_PCT;
                        end
                        else
                        begin
                            phase_next   = ped_pkg::PH_IDLE;
                            cand[cand_n] = src_item.in_byte;
                            cand_n       = cand_n + 2'd1;
                        end
                    end
                end
                ped_pkg::PH_HEX:
                begin
                    if (cur_hex.ok)
                    begin
                        cand[cand_n] = {held_hex.val, cur_hex.val};
                        cand_n       = cand_n + 2'd1;
                        phase_next   = ped_pkg::PH_IDLE;
                        held_next    = ped_pkg::CHAR_NUL;
                    end
                    else
                    begin
                        cand[cand_n] = ped_pkg::CHAR_PERCENT;
                        cand_n       = cand_n + 2'd1;
                        cand[cand_n] = held_reg;
                        cand_n       = cand_n + 2'd1;
                        held_next    = ped_pkg::CHAR_NUL;
                        if (src_item.in_byte == ped_pkg::CHAR_PERCENT)
                        begin
                            phase_next = ped_pkg::PH_PCT;
                        end
                        else
                        begin
                            phase_next   = ped_pkg::PH_IDLE;
                            cand[cand_n] = src_item.in_byte;
                            cand_n       = cand_n + 2'd1;
                        end
                    end
                end
                default:
                begin
                    if (src_item.in_byte == ped_pkg::CHAR_PERCENT)
                    begin
                        phase_next = ped_pkg::PH_PCT;
                    end
                    else
                    begin
                        phase_next   = ped_pkg::PH_IDLE;
                        cand[cand_n] = src_item.in_byte;
                        cand_n       = cand_n + 2'd1;
                    end
                end
            endcase
        end

        // At the end of a string any held characters go out literally.
        if (str_end)
        begin
            if (phase_next == ped_pkg::PH_PCT)
            begin
                cand[cand_n] = ped_pkg::CHAR_PERCENT;
                cand_n       = cand_n + 2'd1;
            end
            else if (phase_next == ped_pkg::PH_HEX)
            begin
                cand[cand_n] = ped_pkg::CHAR_PERCENT;
                cand_n       = cand_n + 2'd1;
                cand[cand_n] = held_next;
                cand_n       = cand_n + 2'd1;
            end
            phase_next = ped_pkg::PH_IDLE;
            held_next  = ped_pkg::CHAR_NUL;
        end
    end

    // Apply the cap: only the leading bytes that still fit are kept.
    always_comb
    begin
        room = (count_reg < cap_reg) ? (cap_reg - count_reg) : '0;
        if (room >= ped_pkg::COUNT_BITS'(3))
        begin
            room_sat = 2'd3;
        end
        else
        begin
            room_sat = room[1:0];
        end
        emit_n = (cand_n < room_sat) ? cand_n : room_sat;
    end

    // Build the queue item; an end with no bytes becomes an empty marker.
    always_comb
    begin
        push_op.bytes[0] = cand[0];
        push_op.bytes[1] = cand[1];
        push_op.bytes[2] = cand[2];
        push_op.str_end  = str_end;
        push_op.base     = count_reg;
        if (emit_n == 2'd0)
        begin
            push_op.num      = 2'd1;
            push_op.has_byte = 1'b0;
            push_op.bytes[0] = ped_pkg::CHAR_NUL;
        end
        else
        begin
            push_op.num      = emit_n;
            push_op.has_byte = 1'b1;
        end
        push       = accept && ((emit_n != 2'd0) || str_end);
        count_next = str_end ? '0 : (count_reg + ped_pkg::COUNT_BITS'(emit_n));
    end

    // Escape state and byte counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ped_pkg::PH_IDLE;
            held_reg  <= ped_pkg::CHAR_NUL;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

    // The cap register holds the effective cap derived from the written limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= ped_pkg::cap_of(ped_pkg::LIMIT_RESET);
        end
        else if (limit_wr_en)
        begin
            cap_reg <= ped_pkg::cap_of(limit_wr_data);
        end
    end

    // A held hex digit exists only while a two-character escape is pending.
    `PED_ASSERT_IMP(a_held_clear, clk, rst_n, phase_reg != ped_pkg::PH_HEX, held_reg == ped_pkg::CHAR_NUL, "held digit outside escape")
    // A string end always leaves the counter cleared.
    `PED_ASSERT_NXT(a_end_clears, clk, rst_n, accept && str_end, count_reg == '0, "count not cleared at string end")

endmodule

// ===== rtl/core/ped_queue.sv =====
// Short queue of work items between the front and the back.
// Depends on ped_pkg and the assertion macros.
`include "percent_escape_decoder_macros.svh"

module ped_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ped_pkg::ped_op_t     push_op,
    input  logic                 pop,
    output ped_pkg::ped_op_t     head_op,
    output ped_pkg::ped_qstat_t  qstat
);

    ped_pkg::ped_op_t                 mem [ped_pkg::QUEUE_DEPTH];
    logic [ped_pkg::QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [ped_pkg::QPTR_W:0]         fill_reg, fill_next;

    assign qstat.full  = (fill_reg == (ped_pkg::QPTR_W+1)'(ped_pkg::QUEUE_DEPTH));
    assign qstat.empty = (fill_reg == '0);
    assign head_op     = mem[rd_ptr_reg];

    // Fill level follows pushes and pops.
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    // The front never writes a full queue and the back never reads an empty one.
    `PED_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !qstat.full, "push into full queue")
    `PED_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, !qstat.empty, "pop from empty queue")
    // Pointers stay consistent with the fill level.
    `PED_ASSERT_IMP(a_ptr_match, clk, rst_n, qstat.empty, wr_ptr_reg == rd_ptr_reg, "pointers differ while empty")

endmodule

// ===== rtl/core/ped_back.sv =====
// Back end: walks the bytes of each queued item and drives the output register.
// Depends on ped_pkg and the assertion macros.
`include "percent_escape_decoder_macros.svh"

module ped_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ped_pkg::ped_qstat_t  qstat,
    input  ped_pkg::ped_op_t     head_op,
    output logic                 pop,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output ped_pkg::ped_out_t    dst_item
);

    logic [1:0]                       idx_reg, idx_next;
    logic                             valid_reg, valid_next;
    ped_pkg::ped_out_t                item_reg, item_next;
    logic                             load;
    logic                             take;
    logic                             last_of_op;
    logic [ped_pkg::COUNT_BITS-1:0]   total;

    assign dst_valid  = valid_reg;
    assign dst_item   = item_reg;
    assign load       = !valid_reg || !dst_stall;
    assign take       = load && !qstat.empty;
    assign last_of_op = (idx_reg == (head_op.num - 2'd1));
    assign pop        = take && last_of_op;

    // Form the next result from the head item and the byte index.
    always_comb
    begin
        if (head_op.has_byte)
        begin
            total = head_op.base + ped_pkg::COUNT_BITS'(idx_reg) + ped_pkg::COUNT_BITS'(1);
        end
        else
        begin
            total = head_op.base;
        end
        item_next.out_byte    = head_op.bytes[idx_reg];
        item_next.byte_valid  = head_op.has_byte;
        item_next.run_last    = last_of_op;
        item_next.string_done = last_of_op && head_op.str_end;
        item_next.out_total   = ped_pkg::to_total(total);

        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = take;
        end
        if (take)
        begin
            idx_next = last_of_op ? 2'd0 : (idx_reg + 2'd1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    // The byte index never runs past the head item's result count.
    `PED_ASSERT_IMP(a_idx_range, clk, rst_n, !qstat.empty, (head_op.num != 2'd0) && (idx_reg < head_op.num), "byte index out of range")

endmodule

// ===== rtl/core/percent_escape_decoder.sv =====
// Percent escape decoder, top level: input channel, front, queue, back.
// Depends on ped_pkg, ped_front, ped_queue and ped_back.
//
// Usage: encoded bytes enter on the src channel (src_valid, src_stall,
// src_item), one per transaction; a zero byte or in_last ends a string.
// Decoded results leave on the dst channel, one per transaction, each
// with out_byte, byte_valid, run_last, string_done and the running
// out_total. An input causes zero to three results; a string end with
// nothing to emit yields one empty end marker. limit_wr_en/limit_wr_data
// set the per-string output cap (reset 65535); the user must write it
// only while the block is idle, which the block does not enforce. The
// first result of an input passes through the queue, then the output
// register. Throughput: one input per cycle while each input yields at
// most one result and dst_stall is low; the back delivers one result per
// cycle while dst_stall is low. A four-entry queue between front and back
// absorbs bursts; src_stall rises only when that queue is full. Reset
// clears the escape state, counter, queue and output valid flag. When
// dst_stall is high the output holds, the queue fills, the input stalls.

module percent_escape_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  ped_pkg::ped_in_t              src_item,
    output logic                          dst_valid,
    input  logic                          dst_stall,
    output ped_pkg::ped_out_t             dst_item,
    input  logic                          limit_wr_en,
    input  logic [ped_pkg::LIMIT_W-1:0]   limit_wr_data
);

    ped_pkg::ped_qstat_t qstat;
    ped_pkg::ped_op_t    push_op;
    ped_pkg::ped_op_t    head_op;
    logic                push;
    logic                pop;

    // Classification, escape tracking and cap.
    ped_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .src_item      (src_item),
        .limit_wr_en   (limit_wr_en),
        .limit_wr_data (limit_wr_data),
        .qstat         (qstat),
        .push          (push),
        .push_op       (push_op)
    );

    // Decoupling queue.
    ped_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .qstat   (qstat)
    );

    // Result serializer and output register.
    ped_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .head_op   (head_op),
        .pop       (pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

endmodule

// ===== dv/ped_decode_checker.sv =====
// Checker for the percent escape decoder: watches both channels, predicts results.
// Depends on ped_pkg for the transaction types, phase codes and character constants.
module ped_decode_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        src_valid,
    input  logic                        src_stall,
    input  ped_pkg::ped_in_t            src_item,
    input  logic                        dst_valid,
    input  logic                        dst_stall,
    input  ped_pkg::ped_out_t           dst_item,
    input  logic                        limit_wr_en,
    input  logic [ped_pkg::LIMIT_W-1:0] limit_wr_data,
    output int                          mismatches,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ped_pkg::*;

    // Predicted decoder state and the output cap register.
    ped_phase_t            esc_state;
    logic [7:0]            held_digit;
    logic [COUNT_BITS-1:0] byte_count;
    logic [LIMIT_W-1:0]    limit_reg;

    // Results of the input transaction being decoded, and those still awaited.
    ped_out_t step_res [0:2];
    int       step_n;
    ped_out_t decoded_q [$];
    int       err_cnt;

    // Returns {is_hex, value} for one character.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= CHAR_DIGIT0 && c <= CHAR_DIGIT9)
            return {1'b1, 4'(c - CHAR_DIGIT0)};
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
            return {1'b1, 4'(c - CHAR_LOWER_A + 8'd10)};
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
            return {1'b1, 4'(c - CHAR_UPPER_A + 8'd10)};
        return 5'd0;
    endfunction

    // Write one output character unless the string has reached its cap.
    task automatic emit_char(input logic [7:0] c);
        longint unsigned cmax;
        longint unsigned cap;
        ped_out_t        r;
        cmax = (64'd1 << COUNT_BITS) - 1;
        cap = (longint'(limit_reg) < cmax) ? longint'(limit_reg) : cmax;
        if (byte_count >= cap)
            return;
        byte_count = byte_count + 1'b1;
        r.out_byte    = c;
        r.byte_valid  = 1'b1;
        r.run_last    = 1'b0;
        r.string_done = 1'b0;
        r.out_total   = TOTAL_W'(byte_count);
        step_res[step_n] = r;
        step_n++;
    endtask

    // Handle a character as if no escape were pending.
    task automatic start_fresh(input logic [7:0] c);
        if (c == CHAR_PERCENT) begin
            esc_state = PH_PCT;
        end
        else begin
            esc_state = PH_IDLE;
            emit_char(c);
        end
    endtask

    // Decode one input transaction and queue the results it causes.
    task automatic decode_input(input ped_in_t item);
        logic [7:0] c;
        logic       fin;
        logic [4:0] lo;
        logic [4:0] hi;
        ped_out_t   r;
        c = item.in_byte;
        fin = item.in_last || (c == CHAR_NUL);
        step_n = 0;

        // Escape tracking on a nonzero character.
        if (c != CHAR_NUL) begin
            case (esc_state)
                PH_PCT:
                begin
                    lo = hex_digit(c);
                    if (lo[4]) begin
                        held_digit = c;
                        esc_state = PH_HEX;
                    end
                    else begin
                        emit_char(CHAR_PERCENT);
                        start_fresh(c);
                    end
                end
                PH_HEX:
                begin
                    lo = hex_digit(c);
                    if (lo[4]) begin
                        hi = hex_digit(held_digit);
                        esc_state = PH_IDLE;
                        held_digit = 8'd0;
                        emit_char({hi[3:0], lo[3:0]});
                    end
                    else begin
                        emit_char(CHAR_PERCENT);
                        emit_char(held_digit);
                        held_digit = 8'd0;
                        start_fresh(c);
                    end
                end
                default:
                    start_fresh(c);
            endcase
        end

        // String end: flush a dangling escape, mark the final result.
        if (fin) begin
            if (esc_state == PH_PCT) begin
                emit_char(CHAR_PERCENT);
            end
            else if (esc_state == PH_HEX) begin
                emit_char(CHAR_PERCENT);
                emit_char(held_digit);
            end
            if (step_n == 0) begin
                r.out_byte    = 8'd0;
                r.byte_valid  = 1'b0;
                r.run_last    = 1'b0;
                r.string_done = 1'b0;
                r.out_total   = TOTAL_W'(byte_count);
                step_res[0] = r;
                step_n = 1;
            end
            step_res[step_n-1].string_done = 1'b1;
            esc_state = PH_IDLE;
            held_digit = 8'd0;
            byte_count = '0;
        end

        if (step_n > 0)
            step_res[step_n-1].run_last = 1'b1;
        for (int k = 0; k < step_n; k++)
            decoded_q.push_back(step_res[k]);
    endtask

    // Sample both channels at each edge; compare first, then predict.
    always @(posedge clk or negedge rst_n) begin : watch
        ped_out_t want;
        if (!rst_n) begin
            esc_state  = PH_IDLE;
            held_digit = 8'd0;
            byte_count = '0;
            limit_reg  = LIMIT_RESET;
            decoded_q.delete();
            err_cnt = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else begin
            if (limit_wr_en)
                limit_reg = limit_wr_data;

            // Output transaction against the oldest awaited result.
            if (dst_valid && !dst_stall) begin
                if (decoded_q.size() == 0) begin
                    if (err_cnt < 10)
                        $display("ERROR: unexpected result byte=%h valid=%b run_last=%b done=%b total=%0d",
                                 dst_item.out_byte, dst_item.byte_valid, dst_item.run_last,
                                 dst_item.string_done, dst_item.out_total);
                    err_cnt++;
                end
                else begin
                    want = decoded_q.pop_front();
                    if (dst_item.out_byte !== want.out_byte ||
                        dst_item.byte_valid !== want.byte_valid ||
                        dst_item.run_last !== want.run_last ||
                        dst_item.string_done !== want.string_done ||
                        dst_item.out_total !== want.out_total) begin
                        if (err_cnt < 10) begin
                            $display("ERROR: expected byte=%h valid=%b run_last=%b done=%b total=%0d",
                                     want.out_byte, want.byte_valid, want.run_last,
                                     want.string_done, want.out_total);
                            $display("       actual   byte=%h valid=%b run_last=%b done=%b total=%0d",
                                     dst_item.out_byte, dst_item.byte_valid, dst_item.run_last,
                                     dst_item.string_done, dst_item.out_total);
                        end
                        err_cnt++;
                    end
                end
            end

            // Input transaction: predict its results.
            if (src_valid && !src_stall)
                decode_input(src_item);

            mismatches <= err_cnt;
            pending <= decoded_q.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the percent escape decoder testbench: clock, reset, stimulus and verdict.
// Depends on ped_pkg, the percent_escape_decoder RTL and ped_decode_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ped_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 100;
    localparam int PHASE_ITEMS = 52;

    logic               clk;
    logic               rst_n;
    logic               src_valid;
    logic               src_stall;
    ped_in_t            src_item;
    logic               dst_valid;
    logic               dst_stall;
    ped_out_t           dst_item;
    logic               limit_wr_en;
    logic [LIMIT_W-1:0] limit_wr_data;
    int                 mismatches;
    int                 pending;

    // Idle modes of both sides and the long receiver hold-off request.
    logic tx_free;
    logic rx_free;
    logic hold_req;
    int   sent_items;

    percent_escape_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .src_item      (src_item),
        .dst_valid     (dst_valid),
        .dst_stall     (dst_stall),
        .dst_item      (dst_item),
        .limit_wr_en   (limit_wr_en),
        .limit_wr_data (limit_wr_data)
    );

    ped_decode_checker decode_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .src_item      (src_item),
        .dst_valid     (dst_valid),
        .dst_stall     (dst_stall),
        .dst_item      (dst_item),
        .limit_wr_en   (limit_wr_en),
        .limit_wr_data (limit_wr_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Random character helpers for the encoded strings.
    function automatic logic [7:0] hex_text(input logic [3:0] v);
        if (v < 4'd10)
            return CHAR_DIGIT0 + 8'(v);
        if ($urandom_range(0, 1) == 1)
            return CHAR_UPPER_A + 8'(v - 4'd10);
        return CHAR_LOWER_A + 8'(v - 4'd10);
    endfunction

    function automatic logic [7:0] plain_char();
        if ($urandom_range(0, 1) == 1)
            return 8'($urandom_range(32, 126));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while ((c >= CHAR_DIGIT0 && c <= CHAR_DIGIT9) ||
               (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) ||
               (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F))
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    // Offer one input transaction and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_free ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item.in_byte <= b;
        src_item.in_last <= last;
        @(posedge clk);
        while (src_stall) @(posedge clk);
        sent_items++;
    endtask

    task automatic send_text(input string s, input logic last_on_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_on_end && (i == s.len() - 1));
    endtask

    // One well-formed string: plain characters, escapes, broken and dangling escapes.
    task automatic send_encoded_string();
        int ntok;
        int kind;
        ntok = $urandom_range(0, 8);
        for (int k = 0; k < ntok; k++)
        begin
            kind = $urandom_range(0, 11);
            if (kind < 5)
            begin
                send_byte(plain_char(), 1'b0);
            end
            else
            begin
                send_byte(CHAR_PERCENT, 1'b0);
                if (kind <= 7)
                begin
                    send_byte(hex_text(4'($urandom_range(0, 15))), 1'b0);
                    send_byte(hex_text(4'($urandom_range(0, 15))), 1'b0);
                end
                else if (kind == 8)
                begin
                    send_byte(non_hex_char(), 1'b0);
                end
                else if (kind == 9)
                begin
                    send_byte(hex_text(4'($urandom_range(0, 15))), 1'b0);
                    send_byte(non_hex_char(), 1'b0);
                end
                else if (kind == 11)
                begin
                    send_byte(hex_text(4'($urandom_range(0, 15))), 1'b0);
                end
            end
        end
        if ($urandom_range(0, 1) == 1)
            send_byte(CHAR_NUL, 1'($urandom_range(0, 1)));
        else
            send_byte(plain_char(), 1'b1);
    endtask

    // Drop valid and let every awaited result drain out.
    task automatic wait_idle();
        src_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        wait_idle();
        limit_wr_en <= 1'b1;
        limit_wr_data <= v;
        @(posedge clk);
        limit_wr_en <= 1'b0;
    endtask

    // Receiver: random stalls per result, or a long hold-off on request.
    initial
    begin : receiver
        int n;
        forever
        begin
            if (hold_req)
            begin
                dst_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                n = rx_free ? 0 : $urandom_range(0, 11);
                if (n > 0)
                begin
                    dst_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                dst_stall <= 1'b0;
                @(posedge clk);
                while (!dst_valid && !hold_req) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
                idle = 0;
            else
                idle++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Main stimulus.
    initial
    begin : stimulus
        logic [LIMIT_W-1:0] limits [0:4];
        int                 phase_start;
        logic               hold_done;
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_item = '0;
        dst_stall = 1'b0;
        limit_wr_en = 1'b0;
        limit_wr_data = '0;
        tx_free = 1'b0;
        rx_free = 1'b0;
        hold_req = 1'b0;
        sent_items = 0;
        hold_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: escapes of both cases, broken escapes, string ends mid-escape.
        send_text("%09%fF%Aa%4g", 1'b0);
        send_text("%%", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CHAR_PERCENT, 1'b1);
        send_text("%7", 1'b0);
        send_byte(CHAR_NUL, 1'b1);
        send_text("%20", 1'b1);
        send_text("%5z", 1'b1);
        send_byte(CHAR_NUL, 1'b1);

        // Directed: zero cap drops everything, small cap cuts a string short.
        write_limit('0);
        send_text("a%41", 1'b1);
        send_byte(CHAR_NUL, 1'b0);
        write_limit(16'd2);
        send_text("abc", 1'b1);
        send_text("x%4", 1'b0);
        send_byte(CHAR_NUL, 1'b0);

        // Random phases, each with its own cap and idle pattern.
        limits[0] = 16'd1;
        limits[1] = 16'd3;
        limits[2] = 16'hFFFF;
        limits[3] = 16'($urandom_range(4, 12));
        limits[4] = 16'($urandom_range(0, 65535));
        for (int ph = 0; ph < 5; ph++)
        begin
            write_limit(limits[ph]);
            tx_free = (ph == 1 || ph == 2 || ph == 4);
            rx_free = (ph == 3 || ph == 4);
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS)
            begin
                // Long receiver hold-off while the sender keeps offering.
                if (ph == 2 && !hold_done && sent_items - phase_start >= 16)
                begin
                    hold_req <= 1'b1;
                    hold_done = 1'b1;
                end
                if ($urandom_range(0, 9) < 8)
                    send_encoded_string();
                else
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
            send_byte(plain_char(), 1'b1);
        end

        // Drain and give the verdict.
        rx_free = 1'b1;
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
